// File: rtl/core/asgs_pkg.sv
`timescale 1ns / 1ps
package asgs_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int SUM_W          = SAMPLE_W + 2;
  localparam int PROD_W         = SAMPLE_W + GAIN_W + 1;
  localparam int RND_W          = PROD_W - GAIN_FRAC_BITS;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  localparam logic [0:0] REG_GAIN = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } entry_t;

  typedef struct packed {
    logic [1:0] n;
    entry_t     e0;
    entry_t     e1;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } qstat_t;

endpackage

// File: rtl/core/audio_smooth_gain_saturate.sv
`timescale 1ns / 1ps
// pipeline: a result passes the queue, the multiplier register and the output register;
//   smoothing needs one sample of lookahead, so a sample's result follows the next transfer
// throughput: one input transfer and one result per cycle while out_stall is low; the
//   back end multiplier is pipelined, and a block end queues two results, which stalls
//   input while fewer than two queue slots are free
// reset: synchronous, clears filter state and queue, gain returns to unity (4096)
module audio_smooth_gain_saturate import asgs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       block_end_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [GAIN_W-1:0] gain_q12;
  push_t             push;
  qstat_t            qstat;
  entry_t            head;
  logic              pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == REG_GAIN) ? 32'(gain_q12) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q12 <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_GAIN) begin
      gain_q12 <= pwdata[GAIN_W-1:0];
    end
  end

  asgs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .block_end (block_end),
    .qstat     (qstat),
    .push      (push)
  );

  asgs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  asgs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .gain          (gain_q12),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .block_end_out (block_end_out)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !qstat.not_empty))
    else $error("pop from empty queue");

  a_end_queues: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && block_end |=> qstat.not_empty)
    else $error("block end transfer queued nothing");

endmodule

// File: rtl/core/asgs_front.sv
`timescale 1ns / 1ps
module asgs_front import asgs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       block_end,
  input  qstat_t                     qstat,
  output push_t                      push
);

  logic signed [SAMPLE_W-1:0] prev_smoothed;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic                       holding;
  logic                       held_is_first;

  logic                       accept;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] v;

  // two free slots needed, a block end may produce two results
  assign in_stall = qstat.count > QCNT_W'(QDEPTH - 2);
  assign accept   = in_valid && !in_stall;

  // floor((p + 2c + n) / 4) by arithmetic shift
  assign sum = SUM_W'(prev_smoothed) + {held_sample[SAMPLE_W-1], held_sample, 1'b0}
             + SUM_W'(sample_in);
  assign v   = held_is_first ? held_sample : sum[SUM_W-1:2];

  always_comb begin
    push          = '0;
    push.e0.value = v;
    push.e0.last  = 1'b0;
    push.e1.value = sample_in;
    push.e1.last  = 1'b1;
    if (accept) begin
      if (!holding) begin
        if (block_end) begin
          push.n        = 2'd1;
          push.e0.value = sample_in;
          push.e0.last  = 1'b1;
        end
      end else begin
        push.n = block_end ? 2'd2 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_smoothed <= '0;
      held_sample   <= '0;
      holding       <= 1'b0;
      held_is_first <= 1'b1;
    end else if (accept) begin
      if (!holding) begin
        held_is_first <= 1'b1;
        if (!block_end) begin
          held_sample <= sample_in;
          holding     <= 1'b1;
        end
      end else begin
        prev_smoothed <= v;
        if (block_end) begin
          holding       <= 1'b0;
          held_is_first <= 1'b1;
        end else begin
          held_sample   <= sample_in;
          held_is_first <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/core/asgs_queue.sv
`timescale 1ns / 1ps
module asgs_queue import asgs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  logic   pop,
  output entry_t head,
  output qstat_t qstat
);

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QPTR_W-1:0] wr_ptr1;

  assign wr_ptr1         = wr_ptr + QPTR_W'(1);
  assign head            = mem[rd_ptr];
  assign qstat.count     = count;
  assign qstat.not_empty = count != '0;

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

endmodule

// File: rtl/core/asgs_back.sv
`timescale 1ns / 1ps
module asgs_back import asgs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [GAIN_W-1:0]          gain,
  input  entry_t                     head,
  input  qstat_t                     qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       block_end_out
);

  logic                     m_valid;
  logic signed [PROD_W-1:0] m_prod;
  logic                     m_last;

  logic                     out_load;
  logic                     m_load;
  logic signed [GAIN_W:0]   gain_s;
  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        rsum;
  logic [RND_W-1:0]         r;
  logic signed [SAMPLE_W-1:0] sat;

  assign out_load = !out_valid || !out_stall;
  assign m_load   = !m_valid || out_load;
  assign pop      = m_load && qstat.not_empty;
  assign gain_s   = {1'b0, gain};

  // round half away from zero on the magnitude, then saturate
  assign neg  = m_prod[PROD_W-1];
  assign mag  = neg ? PROD_W'(-m_prod) : PROD_W'(m_prod);
  assign rsum = mag + (PROD_W'(1) << (GAIN_FRAC_BITS - 1));
  assign r    = rsum[PROD_W-1:GAIN_FRAC_BITS];

  always_comb begin
    if (neg) begin
      sat = (r > RND_W'(32768)) ? SAMPLE_W'(-32768) : SAMPLE_W'(-r);
    end else begin
      sat = (r > RND_W'(32767)) ? SAMPLE_W'(32767) : SAMPLE_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_prod <= PROD_W'(head.value) * PROD_W'(gain_s);
      m_last <= head.last;
    end
    if (out_load && m_valid) begin
      sample_out    <= sat;
      block_end_out <= m_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_load) begin
        m_valid <= qstat.not_empty;
      end
      if (out_load) begin
        out_valid <= m_valid;
      end
    end
  end

endmodule
